// ----- rtl/lav_pkg.sv -----
package lav_pkg;

	localparam int FRAC_BITS = 16;
	localparam int WORD_W    = 32;
	localparam int UNIT_W    = FRAC_BITS + 2;          // unit component, |c| <= 1.0
	localparam int UIN_W     = WORD_W + UNIT_W;        // signed input to the normaliser
	localparam int MAG_W     = UIN_W - 1;
	localparam int P_W       = $clog2(MAG_W);
	localparam int TOP_BIT   = 29;                     // block scaling puts the top one here
	localparam int SCL_W     = TOP_BIT + 1;
	localparam int SQ_W      = 2 * SCL_W;
	localparam int SUM_W     = SQ_W + 2;
	localparam int LEN_W     = SUM_W / 2;
	localparam int QUO_W     = FRAC_BITS + 1;
	localparam int NUM_W     = SCL_W + QUO_W;
	localparam int PV_W      = 2 * UNIT_W;
	localparam int DOT_W     = UIN_W + 2;
	localparam int SIDE_W    = 6 * WORD_W;
	localparam int PAD_W     = SIDE_W - 3 * WORD_W - 3 * UNIT_W;
	localparam int RND       = 1 << (FRAC_BITS - 1);
	localparam int ONE       = 1 << FRAC_BITS;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [UNIT_W-1:0] unit_t;
	typedef logic signed [UIN_W-1:0]  uin_t;
	typedef logic signed [DOT_W-1:0]  dot_t;
	typedef logic [SIDE_W-1:0]        side_t;

	typedef struct packed {
		word_t [2:0] eye;
		word_t [2:0] up;
	} side_a_t;

	typedef struct packed {
		word_t [2:0]      eye;
		unit_t [2:0]      n;
		logic [PAD_W-1:0] pad;
	} side_b_t;

	typedef struct packed {
		word_t eye_x;
		word_t eye_y;
		word_t eye_z;
		word_t target_x;
		word_t target_y;
		word_t target_z;
		word_t upvec_x;
		word_t upvec_y;
		word_t upvec_z;
	} req_t;

	typedef struct packed {
		word_t right_x;
		word_t right_y;
		word_t right_z;
		word_t right_offset;
		word_t upaxis_x;
		word_t upaxis_y;
		word_t upaxis_z;
		word_t upaxis_offset;
		word_t back_x;
		word_t back_y;
		word_t back_z;
		word_t back_offset;
	} rsp_t;

endpackage

// ----- rtl/look_at_view_matrix_top.sv -----
// Throughput: one item per cycle while the result side does not stall; the two
// square-root/divide normalisers are fully pipelined, one root bit and one quotient bit per stage.
// A stall on the result side freezes the whole pipeline and stalls the request side.
// Reset (arst_n low, asynchronous) clears all valid bits; data registers are not reset.
module look_at_view_matrix_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  lav_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output lav_pkg::rsp_t rsp
);
	import lav_pkg::*;

	logic         en;
	logic         v_s1;
	uin_t  [2:0]  nraw_s1;
	side_a_t      sa_s1;

	logic         n_valid;
	unit_t [2:0]  n_vec;
	side_t        n_side;
	logic         x_valid;
	uin_t  [2:0]  x_raw;
	side_t        x_side;
	logic         u_valid;
	unit_t [2:0]  u_vec;
	side_t        u_side;

	assign req_stall = rsp_valid & rsp_stall;
	assign en        = ~req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nraw_s1[0] <= uin_t'(req.eye_x) - uin_t'(req.target_x);
			nraw_s1[1] <= uin_t'(req.eye_y) - uin_t'(req.target_y);
			nraw_s1[2] <= uin_t'(req.eye_z) - uin_t'(req.target_z);
			sa_s1.eye  <= {req.eye_x, req.eye_y, req.eye_z};
			sa_s1.up   <= {req.upvec_x, req.upvec_y, req.upvec_z};
		end
	end

	// array index 0 is x: packed word lists above go x first, which puts x at index 2, so the side words are swapped back
	uin_t [2:0] nraw_c;
	always_comb begin
		nraw_c[0] = nraw_s1[0];
		nraw_c[1] = nraw_s1[1];
		nraw_c[2] = nraw_s1[2];
	end

	side_a_t sa_c;
	always_comb begin
		sa_c.eye[0] = sa_s1.eye[2];
		sa_c.eye[1] = sa_s1.eye[1];
		sa_c.eye[2] = sa_s1.eye[0];
		sa_c.up[0]  = sa_s1.up[2];
		sa_c.up[1]  = sa_s1.up[1];
		sa_c.up[2]  = sa_s1.up[0];
	end

	lav_unitize u_norm_n (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.in_vec    (nraw_c),
		.in_side   (side_t'(sa_c)),
		.out_valid (n_valid),
		.out_vec   (n_vec),
		.out_side  (n_side)
	);

	lav_cross u_cross (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (n_valid),
		.n         (n_vec),
		.in_side   (n_side),
		.out_valid (x_valid),
		.uraw      (x_raw),
		.out_side  (x_side)
	);

	lav_unitize u_norm_u (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (x_valid),
		.in_vec    (x_raw),
		.in_side   (x_side),
		.out_valid (u_valid),
		.out_vec   (u_vec),
		.out_side  (u_side)
	);

	lav_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (u_valid),
		.u         (u_vec),
		.in_side   (u_side),
		.out_valid (rsp_valid),
		.out_rsp   (rsp)
	);

	// zero backward axis forces a zero right axis and offset
	a_zero_back: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.back_x == 0 && rsp.back_y == 0 && rsp.back_z == 0 |->
		rsp.right_x == 0 && rsp.right_y == 0 && rsp.right_z == 0 && rsp.right_offset == 0)
		else $error("right axis not zero for zero backward axis");

	a_zero_right: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.right_x == 0 && rsp.right_y == 0 && rsp.right_z == 0 |->
		rsp.upaxis_x == 0 && rsp.upaxis_y == 0 && rsp.upaxis_z == 0)
		else $error("up axis not zero for zero right axis");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |->
		rsp.back_x <= ONE && rsp.back_x >= -ONE &&
		rsp.right_x <= ONE && rsp.right_x >= -ONE)
		else $error("unit axis component beyond one");

endmodule

// ----- rtl/lav_unitize.sv -----
module lav_unitize (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  lav_pkg::uin_t  [2:0]    in_vec,
	input  lav_pkg::side_t          in_side,
	output logic                    out_valid,
	output lav_pkg::unit_t [2:0]    out_vec,
	output lav_pkg::side_t          out_side
);
	import lav_pkg::*;

	localparam int ISQ_N = LEN_W;
	localparam int DIV_N = QUO_W;

	typedef logic [MAG_W-1:0] mag_t;
	typedef logic [SCL_W-1:0] scl_t;
	typedef scl_t [2:0]       scl3_t;
	typedef logic [LEN_W-1:0] len_t;
	typedef len_t [2:0]       len3_t;
	typedef logic [QUO_W-1:0] quo_t;
	typedef quo_t [2:0]       quo3_t;
	typedef logic [NUM_W-1:0] num_t;
	typedef num_t [2:0]       num3_t;

	function automatic logic [P_W-1:0] msb_pos(input mag_t v);
		logic [P_W-1:0] pos;
		pos = '0;
		for (int i = 0; i < MAG_W; i++)
			if (v[i])
				pos = P_W'(i);
		return pos;
	endfunction

	// stage 1: magnitudes
	logic              v_s1;
	mag_t  [2:0]       m_s1;
	logic  [2:0]       neg_s1;
	mag_t              mor_s1;
	side_t             side_s1;
	mag_t  [2:0]       mag_c;

	always_comb begin
		for (int i = 0; i < 3; i++)
			mag_c[i] = in_vec[i][UIN_W-1] ? MAG_W'(-in_vec[i]) : MAG_W'(in_vec[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1    <= mag_c;
			mor_s1  <= mag_c[0] | mag_c[1] | mag_c[2];
			side_s1 <= in_side;
			for (int i = 0; i < 3; i++)
				neg_s1[i] <= in_vec[i][UIN_W-1];
		end
	end

	// stage 2: leading one of the largest magnitude
	logic             v_s2;
	mag_t [2:0]       m_s2;
	logic [2:0]       neg_s2;
	logic [P_W-1:0]   p_s2;
	logic             zero_s2;
	side_t            side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s2    <= m_s1;
			neg_s2  <= neg_s1;
			p_s2    <= msb_pos(mor_s1);
			zero_s2 <= (mor_s1 == '0);
			side_s2 <= side_s1;
		end
	end

	// stage 3: block scaling, top one lands on TOP_BIT
	logic             v_s3;
	scl3_t            sc_s3;
	logic [2:0]       neg_s3;
	logic             zero_s3;
	side_t            side_s3;
	logic [MAG_W+TOP_BIT-1:0] wide_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			wide_c[i] = {m_s2[i], {TOP_BIT{1'b0}}} >> p_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				sc_s3[i] <= wide_c[i][SCL_W-1:0];
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
			side_s3 <= side_s2;
		end
	end

	// stage 4: squares
	logic                  v_s4;
	logic [2:0][SQ_W-1:0]  sq_s4;
	scl3_t                 sc_s4;
	logic [2:0]            neg_s4;
	logic                  zero_s4;
	side_t                 side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				sq_s4[i] <= sc_s3[i] * sc_s3[i];
			sc_s4   <= sc_s3;
			neg_s4  <= neg_s3;
			zero_s4 <= zero_s3;
			side_s4 <= side_s3;
		end
	end

	// stage 5: sum of squares
	logic             v_s5;
	logic [SUM_W-1:0] sum_s5;
	scl3_t            sc_s5;
	logic [2:0]       neg_s5;
	logic             zero_s5;
	side_t            side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s5  <= SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]);
			sc_s5   <= sc_s4;
			neg_s5  <= neg_s4;
			zero_s5 <= zero_s4;
			side_s5 <= side_s4;
		end
	end

	// integer square root, one result bit per stage
	logic             rt_v_s    [ISQ_N];
	logic [SUM_W-1:0] rt_x_s    [ISQ_N];
	logic [SUM_W-1:0] rt_r_s    [ISQ_N];
	scl3_t            rt_sc_s   [ISQ_N];
	logic [2:0]       rt_neg_s  [ISQ_N];
	logic             rt_zero_s [ISQ_N];
	side_t            rt_side_s [ISQ_N];

	for (genvar j = 0; j < ISQ_N; j++) begin : g_rt
		localparam int K = ISQ_N - 1 - j;
		logic             v_in, zero_in;
		logic [SUM_W-1:0] x_in, r_in, x_nx, r_nx, bitv;
		logic [SUM_W:0]   trial;
		scl3_t            sc_in;
		logic [2:0]       neg_in;
		side_t            side_in;

		if (j == 0) begin : g_first
			assign v_in    = v_s5;
			assign x_in    = sum_s5;
			assign r_in    = '0;
			assign sc_in   = sc_s5;
			assign neg_in  = neg_s5;
			assign zero_in = zero_s5;
			assign side_in = side_s5;
		end else begin : g_next
			assign v_in    = rt_v_s[j-1];
			assign x_in    = rt_x_s[j-1];
			assign r_in    = rt_r_s[j-1];
			assign sc_in   = rt_sc_s[j-1];
			assign neg_in  = rt_neg_s[j-1];
			assign zero_in = rt_zero_s[j-1];
			assign side_in = rt_side_s[j-1];
		end

		assign bitv  = {{(SUM_W-1){1'b0}}, 1'b1} << (2 * K);
		assign trial = {1'b0, r_in} + {1'b0, bitv};

		always_comb begin
			if ({1'b0, x_in} >= trial) begin
				x_nx = x_in - trial[SUM_W-1:0];
				r_nx = (r_in >> 1) + bitv;
			end else begin
				x_nx = x_in;
				r_nx = r_in >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rt_v_s[j] <= 1'b0;
			else if (en) rt_v_s[j] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_x_s[j]    <= x_nx;
				rt_r_s[j]    <= r_nx;
				rt_sc_s[j]   <= sc_in;
				rt_neg_s[j]  <= neg_in;
				rt_zero_s[j] <= zero_in;
				rt_side_s[j] <= side_in;
			end
		end
	end

	// stage 6: dividends with half the length added for rounding
	logic       v_s6;
	num3_t      num_s6;
	len_t       len_s6;
	logic [2:0] neg_s6;
	logic       zero_s6;
	side_t      side_s6;
	len_t       len_c;

	assign len_c = rt_r_s[ISQ_N-1][LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= rt_v_s[ISQ_N-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				num_s6[i] <= (NUM_W'(rt_sc_s[ISQ_N-1][i]) << FRAC_BITS) + NUM_W'(len_c >> 1);
			len_s6  <= len_c;
			neg_s6  <= rt_neg_s[ISQ_N-1];
			zero_s6 <= rt_zero_s[ISQ_N-1];
			side_s6 <= rt_side_s[ISQ_N-1];
		end
	end

	// restoring division, one quotient bit per stage, three lanes
	logic       dv_v_s    [DIV_N];
	len3_t      dv_r_s    [DIV_N];
	quo3_t      dv_q_s    [DIV_N];
	num3_t      dv_num_s  [DIV_N];
	len_t       dv_len_s  [DIV_N];
	logic [2:0] dv_neg_s  [DIV_N];
	logic       dv_zero_s [DIV_N];
	side_t      dv_side_s [DIV_N];

	for (genvar d = 0; d < DIV_N; d++) begin : g_dv
		logic   v_in, zero_in;
		len3_t  r_in, r_nx;
		quo3_t  q_in, q_nx;
		num3_t  num_in;
		len_t   len_in;
		logic [2:0] neg_in;
		side_t  side_in;

		if (d == 0) begin : g_first
			assign v_in   = v_s6;
			assign num_in = num_s6;
			assign len_in = len_s6;
			assign neg_in = neg_s6;
			assign zero_in = zero_s6;
			assign side_in = side_s6;
			assign q_in   = '0;
			for (genvar i = 0; i < 3; i++) begin : g_init
				assign r_in[i] = LEN_W'(num_s6[i][NUM_W-1:QUO_W]);
			end
		end else begin : g_next
			assign v_in    = dv_v_s[d-1];
			assign num_in  = dv_num_s[d-1];
			assign len_in  = dv_len_s[d-1];
			assign neg_in  = dv_neg_s[d-1];
			assign zero_in = dv_zero_s[d-1];
			assign side_in = dv_side_s[d-1];
			assign q_in    = dv_q_s[d-1];
			assign r_in    = dv_r_s[d-1];
		end

		always_comb begin
			logic [LEN_W:0] sh;
			for (int i = 0; i < 3; i++) begin
				sh = {r_in[i], num_in[i][QUO_W-1-d]};
				if (sh >= {1'b0, len_in}) begin
					r_nx[i] = LEN_W'(sh - {1'b0, len_in});
					q_nx[i] = {q_in[i][QUO_W-2:0], 1'b1};
				end else begin
					r_nx[i] = sh[LEN_W-1:0];
					q_nx[i] = {q_in[i][QUO_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[d] <= 1'b0;
			else if (en) dv_v_s[d] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_r_s[d]    <= r_nx;
				dv_q_s[d]    <= q_nx;
				dv_num_s[d]  <= num_in;
				dv_len_s[d]  <= len_in;
				dv_neg_s[d]  <= neg_in;
				dv_zero_s[d] <= zero_in;
				dv_side_s[d] <= side_in;
			end
		end
	end

	// stage 7: sign restore; a zero vector stays zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= dv_v_s[DIV_N-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (dv_zero_s[DIV_N-1])
					out_vec[i] <= '0;
				else if (dv_neg_s[DIV_N-1][i])
					out_vec[i] <= -unit_t'(dv_q_s[DIV_N-1][i]);
				else
					out_vec[i] <= unit_t'(dv_q_s[DIV_N-1][i]);
			end
			out_side <= dv_side_s[DIV_N-1];
		end
	end

endmodule

// ----- rtl/lav_cross.sv -----
module lav_cross (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  lav_pkg::unit_t [2:0]  n,
	input  lav_pkg::side_t        in_side,
	output logic                  out_valid,
	output lav_pkg::uin_t  [2:0]  uraw,
	output lav_pkg::side_t        out_side
);
	import lav_pkg::*;

	side_a_t     sa;
	uin_t  [5:0] prod_c;
	logic        v_s1;
	uin_t  [5:0] prod_s1;
	word_t [2:0] eye_s1;
	unit_t [2:0] n_s1;
	side_b_t     sb;

	assign sa = side_a_t'(in_side);

	// up x n
	always_comb begin
		prod_c[0] = $signed(sa.up[1]) * $signed(n[2]);
		prod_c[1] = $signed(sa.up[2]) * $signed(n[1]);
		prod_c[2] = $signed(sa.up[2]) * $signed(n[0]);
		prod_c[3] = $signed(sa.up[0]) * $signed(n[2]);
		prod_c[4] = $signed(sa.up[0]) * $signed(n[1]);
		prod_c[5] = $signed(sa.up[1]) * $signed(n[0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			out_valid <= v_s1;
		end
	end

	always_comb begin
		sb.eye = eye_s1;
		sb.n   = n_s1;
		sb.pad = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= prod_c;
			eye_s1   <= sa.eye;
			n_s1     <= n;
			uraw[0]  <= prod_s1[0] - prod_s1[1];
			uraw[1]  <= prod_s1[2] - prod_s1[3];
			uraw[2]  <= prod_s1[4] - prod_s1[5];
			out_side <= side_t'(sb);
		end
	end

endmodule

// ----- rtl/lav_frame.sv -----
module lav_frame (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  lav_pkg::unit_t [2:0]  u,
	input  lav_pkg::side_t        in_side,
	output logic                  out_valid,
	output lav_pkg::rsp_t         out_rsp
);
	import lav_pkg::*;

	typedef logic signed [PV_W-1:0] pv_t;
	typedef logic signed [PV_W:0]   pvd_t;

	localparam logic signed [DOT_W:0] SAT_HI = {{(DOT_W-WORD_W+2){1'b0}}, {(WORD_W-1){1'b1}}};
	localparam logic signed [DOT_W:0] SAT_LO = {{(DOT_W-WORD_W+2){1'b1}}, {(WORD_W-1){1'b0}}};

	function automatic unit_t round_unit(input pvd_t d);
		logic [PV_W:0] mag;
		logic [PV_W:0] r;
		mag = d[PV_W] ? (PV_W+1)'(-d) : (PV_W+1)'(d);
		r   = (mag + (PV_W+1)'(RND)) >> FRAC_BITS;
		return d[PV_W] ? -unit_t'(r) : unit_t'(r);
	endfunction

	// -(round to nearest, ties away from zero), saturated to a word
	function automatic word_t neg_sat(input dot_t d);
		logic [DOT_W-1:0]     mag;
		logic [DOT_W-1:0]     r;
		logic signed [DOT_W:0] val;
		mag = d[DOT_W-1] ? DOT_W'(-d) : DOT_W'(d);
		r   = (mag + DOT_W'(RND)) >> FRAC_BITS;
		val = d[DOT_W-1] ? $signed({1'b0, r}) : -$signed({1'b0, r});
		if (val > SAT_HI)
			return word_t'(SAT_HI[WORD_W-1:0]);
		else if (val < SAT_LO)
			return word_t'(SAT_LO[WORD_W-1:0]);
		else
			return word_t'(val[WORD_W-1:0]);
	endfunction

	side_b_t sb;
	assign sb = side_b_t'(in_side);

	logic        v_s1, v_s2, v_s3, v_s4;
	pv_t  [5:0]  pv_s1;
	uin_t [2:0]  peu_s1, pen_s1;
	unit_t [2:0] u_s1, n_s1, u_s2, n_s2, v_s2_vec, u_s3, n_s3, v_s3_vec;
	unit_t [2:0] u_s4, n_s4, v_s4_vec;
	word_t [2:0] eye_s1, eye_s2;
	dot_t        du_s2, dn_s2, dv_s4;
	uin_t [2:0]  pev_s3;
	word_t       offu_s3, offn_s3, offu_s4, offn_s4;
	unit_t [2:0] v_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			out_valid <= v_s4;
		end
	end

	// v = n x u
	always_comb begin
		v_c[0] = round_unit(pvd_t'(pv_s1[0]) - pvd_t'(pv_s1[1]));
		v_c[1] = round_unit(pvd_t'(pv_s1[2]) - pvd_t'(pv_s1[3]));
		v_c[2] = round_unit(pvd_t'(pv_s1[4]) - pvd_t'(pv_s1[5]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: products
			pv_s1[0] <= $signed(sb.n[1]) * $signed(u[2]);
			pv_s1[1] <= $signed(sb.n[2]) * $signed(u[1]);
			pv_s1[2] <= $signed(sb.n[2]) * $signed(u[0]);
			pv_s1[3] <= $signed(sb.n[0]) * $signed(u[2]);
			pv_s1[4] <= $signed(sb.n[0]) * $signed(u[1]);
			pv_s1[5] <= $signed(sb.n[1]) * $signed(u[0]);
			for (int i = 0; i < 3; i++) begin
				peu_s1[i] <= $signed(sb.eye[i]) * $signed(u[i]);
				pen_s1[i] <= $signed(sb.eye[i]) * $signed(sb.n[i]);
			end
			u_s1   <= u;
			n_s1   <= sb.n;
			eye_s1 <= sb.eye;

			// stage 2: rounded cross product, dot sums
			v_s2_vec <= v_c;
			du_s2    <= dot_t'(peu_s1[0]) + dot_t'(peu_s1[1]) + dot_t'(peu_s1[2]);
			dn_s2    <= dot_t'(pen_s1[0]) + dot_t'(pen_s1[1]) + dot_t'(pen_s1[2]);
			u_s2     <= u_s1;
			n_s2     <= n_s1;
			eye_s2   <= eye_s1;

			// stage 3
			for (int i = 0; i < 3; i++)
				pev_s3[i] <= $signed(eye_s2[i]) * $signed(v_s2_vec[i]);
			offu_s3  <= neg_sat(du_s2);
			offn_s3  <= neg_sat(dn_s2);
			u_s3     <= u_s2;
			n_s3     <= n_s2;
			v_s3_vec <= v_s2_vec;

			// stage 4
			dv_s4    <= dot_t'(pev_s3[0]) + dot_t'(pev_s3[1]) + dot_t'(pev_s3[2]);
			offu_s4  <= offu_s3;
			offn_s4  <= offn_s3;
			u_s4     <= u_s3;
			n_s4     <= n_s3;
			v_s4_vec <= v_s3_vec;

			// output register
			out_rsp.right_x       <= word_t'(u_s4[0]);
			out_rsp.right_y       <= word_t'(u_s4[1]);
			out_rsp.right_z       <= word_t'(u_s4[2]);
			out_rsp.right_offset  <= offu_s4;
			out_rsp.upaxis_x      <= word_t'(v_s4_vec[0]);
			out_rsp.upaxis_y      <= word_t'(v_s4_vec[1]);
			out_rsp.upaxis_z      <= word_t'(v_s4_vec[2]);
			out_rsp.upaxis_offset <= neg_sat(dv_s4);
			out_rsp.back_x        <= word_t'(n_s4[0]);
			out_rsp.back_y        <= word_t'(n_s4[1]);
			out_rsp.back_z        <= word_t'(n_s4[2]);
			out_rsp.back_offset   <= offn_s4;
		end
	end

endmodule
